@@ src/itra_pkg.sv @@
`timescale 1ns / 1ps

package itra_pkg;

    // fixed field widths
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 7;
    localparam int LEN_W   = 6;
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;

    // default sizing
    localparam int DEF_MAX_DIGITS = 32;
    localparam int DEF_VALUE_BITS = 32;

    // register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_RADIX = 1'b0;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CH_Z     = 7'h5A;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] DEC_DIGITS = 7'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_READ,
        S_LOAD
    } t_state;

    // status from the serial divider
    typedef struct packed {
        logic done;
        logic quo_zero;
    } t_div_sts;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        logic [CHAR_W-1:0] res;
        dx = {1'b0, d};
        if (dx < DEC_DIGITS) begin
            res = CH_ZERO + dx;
        end else begin
            res = CH_A + (dx - DEC_DIGITS);
        end
        return res;
    endfunction

endpackage

@@ src/integer_to_radix_ascii.sv @@
`timescale 1ns / 1ps

// integer to radix ascii converter
//
// input channel: i_value with i_in_valid / o_in_stall; a transfer takes one signed
// integer. output channel: o_out_char, o_last_char, o_text_length with o_out_valid /
// i_out_stall; one transfer per character, most significant digit first. o_last_char
// marks the final character, which also carries the total length (zero otherwise).
// radix register at byte address 0 on the apb port (reset 10, clamped to 2..36 on use);
// write it only while the block is idle. a minus sign is printed in radix ten only.
//
// each digit is one bit-serial division by the radix in the single serial divider. the
// digits then play out of the digit memory through a read state and a load state per
// character, after a sign state for a minus sign. one item is in flight at a time;
// o_in_stall is high from accept until the last character sits in the output
// register, so the next item is taken while that character still waits for the
// receiver.
// a stalled receiver freezes the output register and the character sequencer.
// reset clears control state and the radix; the digit memory needs no clearing.

module integer_to_radix_ascii #(
    parameter int MAX_DIGITS = itra_pkg::DEF_MAX_DIGITS,
    parameter int VALUE_BITS = itra_pkg::DEF_VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // apb configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [itra_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [itra_pkg::APB_DATA_W-1:0] pwdata,
    output logic [itra_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [itra_pkg::VALUE_W-1:0] i_value,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [itra_pkg::CHAR_W-1:0]     o_out_char,
    output logic                            o_last_char,
    output logic [itra_pkg::LEN_W-1:0]      o_text_length
);
    import itra_pkg::*;

    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DIGITS);

    // ---------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------
    logic [RADIX_W-1:0]   r_radix;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_cfg_wr;
    logic [RADIX_W-1:0]   w_radix_eff;

    assign w_reg_idx   = paddr[APB_ADDR_W-1:2];
    assign w_cfg_wr    = psel && penable && pwrite;
    assign pready      = 1'b1;
    assign w_radix_eff = clamp_radix(r_radix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_RADIX: r_radix <= pwdata[RADIX_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_RADIX: prdata = {{(APB_DATA_W-RADIX_W){1'b0}}, r_radix};
            default:   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]   r_count;      // digits collected so far
    logic               r_neg;        // minus sign to print
    logic [ADDR_W-1:0]  r_rd_addr;    // digit being played out
    logic [DIGIT_W-1:0] r_rd_data;
    logic [DIGIT_W-1:0] r_mem [MAX_DIGITS];

    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;
    logic [LEN_W-1:0]   r_out_len;
    logic               r_out_valid;

    // ---------------------------------------------------------------
    // input decode: sign handling only in radix ten
    // ---------------------------------------------------------------
    logic [VALUE_W+63:0]   w_value_ext;
    logic [VALUE_BITS-1:0] w_value;
    logic                  w_neg_in;
    logic [VALUE_BITS-1:0] w_mag;

    always_comb begin
        w_value_ext = {{64{i_value[VALUE_W-1]}}, i_value};
        w_value     = w_value_ext[VALUE_BITS-1:0];
        w_neg_in    = w_value[VALUE_BITS-1] && (w_radix_eff == RADIX_DEC);
        w_mag       = w_neg_in ? (~w_value + 1'b1) : w_value;
    end

    // ---------------------------------------------------------------
    // serial divider
    // ---------------------------------------------------------------
    logic                  w_div_start;
    logic [VALUE_BITS-1:0] w_dividend;
    logic [VALUE_BITS-1:0] w_quotient;
    logic [DIGIT_W-1:0]    w_remainder;
    t_div_sts              w_div_sts;

    itra_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_radix_eff),
        .o_quotient  (w_quotient),
        .o_remainder (w_remainder),
        .o_sts       (w_div_sts)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    logic               w_in_accept;
    logic               w_out_free;
    logic [CNT_W-1:0]   w_count_inc;
    logic               w_more;       // another digit to divide out
    logic [CNT_W:0]     w_total;
    logic [CNT_W+LEN_W:0] w_total_ext;
    logic [LEN_W-1:0]   w_total_len;
    logic               w_mem_we;
    logic               w_load_sign;
    logic               w_load_digit;
    logic               w_rd_first;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_count_inc = r_count + 1'b1;
    assign w_more      = !w_div_sts.quo_zero && (w_count_inc != CNT_FULL);
    assign w_total     = {1'b0, r_count} + {{CNT_W{1'b0}}, r_neg};
    assign w_total_ext = {{LEN_W{1'b0}}, w_total};
    assign w_total_len = w_total_ext[LEN_W-1:0];
    assign w_rd_first  = (r_rd_addr == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    if (w_more) begin
                        n_state = S_DIV;
                    end else if (r_neg) begin
                        n_state = S_SIGN;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_LOAD;
            S_LOAD: begin
                if (w_out_free) begin
                    n_state = w_rd_first ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall   = 1'b1;
        w_div_start  = 1'b0;
        w_dividend   = w_quotient;
        w_mem_we     = 1'b0;
        w_load_sign  = 1'b0;
        w_load_digit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                w_div_start = w_in_accept;
                w_dividend  = w_mag;
            end
            S_DIV: begin
                w_mem_we    = w_div_sts.done;
                w_div_start = w_div_sts.done && w_more;
            end
            S_SIGN: w_load_sign = w_out_free;
            S_READ: ;
            S_LOAD: w_load_digit = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_accept) begin
                r_count <= '0;
                r_neg   <= w_neg_in;
            end else if (w_mem_we) begin
                r_count <= w_count_inc;
            end
            if (w_load_sign || w_load_digit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // digit memory, least significant digit at address zero
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_count[ADDR_W-1:0]] <= w_remainder;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    // read pointer walks down from the top digit
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_rd_addr <= r_count[ADDR_W-1:0];
        end else if (w_load_digit && !w_rd_first) begin
            r_rd_addr <= r_rd_addr - 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load_sign) begin
            r_out_char <= CH_MINUS;
            r_out_last <= (w_total == (CNT_W+1)'(1));
            r_out_len  <= (w_total == (CNT_W+1)'(1)) ? w_total_len : '0;
        end else if (w_load_digit) begin
            r_out_char <= digit_to_ascii(r_rd_data);
            r_out_last <= w_rd_first;
            r_out_len  <= w_rd_first ? w_total_len : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_last_char   = r_out_last;
    assign o_text_length = r_out_len;

endmodule

@@ src/itra_div.sv @@
`timescale 1ns / 1ps

module itra_div #(
    parameter int VALUE_BITS = itra_pkg::DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [VALUE_BITS-1:0]        i_dividend,
    input  logic [itra_pkg::RADIX_W-1:0] i_divisor,
    output logic [VALUE_BITS-1:0]        o_quotient,
    output logic [itra_pkg::DIGIT_W-1:0] o_remainder,
    output itra_pkg::t_div_sts           o_sts
);
    import itra_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

    logic [VALUE_BITS-1:0] r_work;
    logic [DIGIT_W-1:0]    r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic                  r_nz;

    logic [DIGIT_W:0]   w_trial;
    logic [DIGIT_W:0]   w_diff;
    logic               w_ge;
    logic [DIGIT_W-1:0] n_rem;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_work[VALUE_BITS-1]};
        w_ge    = w_trial >= {1'b0, i_divisor};
        w_diff  = w_trial - {1'b0, i_divisor};
        n_rem   = w_ge ? w_diff[DIGIT_W-1:0] : w_trial[DIGIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_nz   <= 1'b0;
        end else if (r_busy) begin
            r_work <= {r_work[VALUE_BITS-2:0], w_ge};
            r_rem  <= n_rem;
            r_nz   <= r_nz | w_ge;
        end
    end

    assign o_quotient     = r_work;
    assign o_remainder    = r_rem;
    assign o_sts.done     = r_done;
    assign o_sts.quo_zero = !r_nz;

endmodule

@@ src/itra_chk.sv @@
`timescale 1ns / 1ps

module itra_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [itra_pkg::CHAR_W-1:0] o_out_char,
    input logic                        o_last_char,
    input logic [itra_pkg::LEN_W-1:0]  o_text_length
);
    import itra_pkg::*;

    // length shows only on the final character, and is never zero there
    a_len_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_char |-> o_text_length != '0)
        else $error("final character without a length");

    a_len_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_char |-> o_text_length == '0)
        else $error("length on a non-final character");

    // a transfer in always keeps the block busy for the division that follows
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transfer");

    // only sign, digits and upper-case letters come out
    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_char == CH_MINUS)
            || (o_out_char >= CH_ZERO && o_out_char <= CH_NINE)
            || (o_out_char >= CH_A && o_out_char <= CH_Z))
        else $error("character outside the digit set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_char)
            && $stable(o_last_char))
        else $error("stalled output changed");

endmodule

bind integer_to_radix_ascii itra_chk u_itra_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_char    (o_out_char),
    .o_last_char   (o_last_char),
    .o_text_length (o_text_length)
);

@@ tb/tb_integer_to_radix_ascii.sv @@
`timescale 1ns / 1ps

module tb_integer_to_radix_ascii;

    import itra_pkg::*;

    localparam int MAX_DIGITS  = DEF_MAX_DIGITS;
    localparam int VALUE_BITS  = DEF_VALUE_BITS;
    // slowest run: ~170 numbers, 32 binary digits each, every character
    // waiting out a long receiver stall; the limit leaves a wide margin
    localparam int unsigned WATCHDOG_NS = 40_000_000;
    // cycles to watch for stray characters once everything has come back
    localparam int SETTLE_CYCLES = 64;
    localparam logic [APB_ADDR_W-1:0] RADIX_ADDR = {REG_RADIX, 2'b00};

    typedef enum {
        JOB_NUMBER,   // one number to convert
        JOB_RADIX,    // radix register write, also sets the idle rates
        JOB_DRAIN     // hold the sender until every character is back
    } t_job_kind;

    typedef struct {
        t_job_kind   kind;
        logic [31:0] data;
        int unsigned send_idle;
        int unsigned recv_idle;
    } t_job;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic [LEN_W-1:0]  len;
    } t_char_result;

    logic i_clk;
    logic rst_n = 1'b0;

    // apb side
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic [1:0]            apb_step = 2'd0;

    // number channel
    logic               in_valid = 1'b0;
    logic [VALUE_W-1:0] in_value = '0;
    logic               in_stall;

    // character channel
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CHAR_W-1:0] out_char;
    logic              out_last;
    logic [LEN_W-1:0]  out_len;

    t_job         jobs[$];
    t_char_result expected_chars[$];

    logic [RADIX_W-1:0] cfg_radix = RADIX_RESET;
    int unsigned send_idle = 20;
    int unsigned recv_idle = 88;

    int numbers_sent   = 0;
    int chars_checked  = 0;
    int radix_writes   = 0;
    int fail_count     = 0;

    integer_to_radix_ascii #(
        .MAX_DIGITS(MAX_DIGITS),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_value      (in_value),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_char   (out_char),
        .o_last_char  (out_last),
        .o_text_length(out_len)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // expected text of one number under the current radix setting:
    // digits are gathered least significant first, then played out
    // most significant first behind an optional minus sign
    function automatic void expect_text(input logic [VALUE_W-1:0] value);
        logic [RADIX_W-1:0] base;
        logic [VALUE_W-1:0] rest;
        logic [DIGIT_W-1:0] digit_buf [MAX_DIGITS];
        logic               neg;
        int                 n;
        int                 total;
        t_char_result       c;
        // out-of-range radix settings are pinned to the nearest legal base
        if (cfg_radix < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (cfg_radix > RADIX_MAX) begin
            base = RADIX_MAX;
        end else begin
            base = cfg_radix;
        end
        // sign is honored in decimal only, elsewhere the value is unsigned
        neg  = value[VALUE_W-1] && (base == RADIX_DEC);
        rest = neg ? -value : value;
        n = 0;
        do begin
            digit_buf[n] = DIGIT_W'(rest % base);
            n++;
            rest = rest / base;
        end while (rest != 0 && n < MAX_DIGITS);
        total = n + int'(neg);
        if (neg) begin
            c.ch   = CH_MINUS;
            c.last = (total == 1);
            c.len  = (total == 1) ? LEN_W'(total) : '0;
            expected_chars.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--) begin
            if (digit_buf[i] < DEC_DIGITS) begin
                c.ch = CH_ZERO + digit_buf[i];
            end else begin
                c.ch = CH_A + (digit_buf[i] - DEC_DIGITS);
            end
            c.last = (i == 0);
            c.len  = (i == 0) ? LEN_W'(total) : '0;
            expected_chars.push_back(c);
        end
    endfunction

    function automatic void add_number(input logic [31:0] v);
        t_job j;
        j.kind = JOB_NUMBER;
        j.data = v;
        j.send_idle = 0;
        j.recv_idle = 0;
        jobs.push_back(j);
    endfunction

    function automatic void add_radix(input logic [31:0] r, input int unsigned s_idle,
                                      input int unsigned r_idle);
        t_job j;
        j.kind = JOB_RADIX;
        j.data = r;
        j.send_idle = s_idle;
        j.recv_idle = r_idle;
        jobs.push_back(j);
    endfunction

    // driver: numbers on the input channel, radix writes on apb.
    // a radix write or a drain only proceeds once the block is idle,
    // i.e. nothing offered and every expected character returned
    always @(posedge i_clk) begin
        t_job j;
        if (!rst_n) begin
            in_valid <= 1'b0;
            psel     <= 1'b0;
            penable  <= 1'b0;
            pwrite   <= 1'b0;
            apb_step <= 2'd0;
        end else begin
            if (in_valid && !in_stall) begin
                expect_text(in_value);
                numbers_sent++;
            end
            if (apb_step == 2'd1) begin
                // access phase
                penable  <= 1'b1;
                apb_step <= 2'd2;
            end else if (apb_step == 2'd2) begin
                if (pready) begin
                    // register takes the write at this edge
                    cfg_radix = pwdata[RADIX_W-1:0];
                    psel     <= 1'b0;
                    penable  <= 1'b0;
                    pwrite   <= 1'b0;
                    apb_step <= 2'd0;
                end
            end else if (in_valid && in_stall) begin
                // stalled transfer: payload holds
            end else if (jobs.size() == 0) begin
                in_valid <= 1'b0;
            end else if (jobs[0].kind == JOB_NUMBER) begin
                if ($urandom_range(0, 99) < send_idle) begin
                    in_valid <= 1'b0;
                end else begin
                    j = jobs.pop_front();
                    in_valid <= 1'b1;
                    in_value <= j.data;
                end
            end else begin
                in_valid <= 1'b0;
                if (!in_valid && expected_chars.size() == 0) begin
                    j = jobs.pop_front();
                    if (j.kind == JOB_RADIX) begin
                        // setup phase
                        psel      <= 1'b1;
                        pwrite    <= 1'b1;
                        penable   <= 1'b0;
                        paddr     <= RADIX_ADDR;
                        pwdata    <= j.data;
                        apb_step  <= 2'd1;
                        send_idle = j.send_idle;
                        recv_idle = j.recv_idle;
                        radix_writes++;
                    end
                end
            end
        end
    end

    // monitor: every character transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_char_result want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    $error("unexpected character %h (last %b, length %0d)",
                           out_char, out_last, out_len);
                    fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (out_char !== want.ch) begin
                        $error("out_char: expected %h, got %h", want.ch, out_char);
                        fail_count++;
                    end
                    if (out_last !== want.last) begin
                        $error("last_char: expected %b, got %b", want.last, out_last);
                        fail_count++;
                    end
                    if (out_len !== want.len) begin
                        $error("text_length: expected %0d, got %0d", want.len, out_len);
                        fail_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    initial begin
        int unsigned s_idle;
        int unsigned r_idle;
        logic [31:0] radix_val;
        logic [31:0] v;
        int unsigned phase_radix [12] = '{10, 3, 36, 2, 10, 7, 35, 16, 0, 10, 0, 8};

        // directed part, first at the reset radix of ten:
        // zero, signs, the most negative value and its neighbors
        add_number(32'd0);
        add_number(32'd1);
        add_number(32'hFFFF_FFFF);
        add_number(32'd9);
        add_number(32'd10);
        add_number(32'h8000_0000);
        add_number(32'h7FFF_FFFF);
        add_number(32'h8000_0001);
        add_number(32'd1_000_000_000);
        // radix below two acts as binary: longest texts
        add_radix(32'd1, 20, 88);
        add_number(32'd0);
        add_number(32'hFFFF_FFFF);
        add_number(32'h8000_0000);
        // radix above thirty-six acts as 36, reaching 'Z'
        add_radix(32'd37, 20, 88);
        add_number(32'd35);
        add_number(32'd36);
        add_number(32'hFFFF_FFFF);
        // all register bits set, upper data bits ignored
        add_radix(32'hFFFF_FFFF, 20, 88);
        add_number(32'h7FFF_FFFF);
        add_number(32'hFFFF_FFF6);
        add_radix(32'd16, 20, 88);
        add_number(32'h89AB_CDEF);
        add_number(32'h0123_4567);
        add_radix(32'd0, 20, 88);
        add_number(32'd1);
        add_number(32'd2);

        // random part: receiver mostly idle, then sender mostly idle, then full rate
        for (int p = 0; p < 12; p++) begin
            s_idle = (p < 4) ? 20 : (p < 8) ? 88 : 0;
            r_idle = (p < 4) ? 88 : (p < 8) ? 20 : 0;
            radix_val = phase_radix[p];
            if (p == 8) begin
                radix_val = $urandom_range(2, 36);
            end
            if (p == 10) begin
                radix_val = $urandom_range(0, 63);
            end
            add_radix(radix_val, s_idle, r_idle);
            for (int k = 0; k < 12; k++) begin
                if (p == 5 && k == 7) begin
                    jobs.push_back('{JOB_DRAIN, 32'd0, 0, 0});
                end
                case ($urandom_range(0, 4))
                    0: v = $urandom;
                    1: v = $urandom_range(0, 99);
                    2: v = -$urandom_range(1, 99);
                    3: v = $urandom >> $urandom_range(0, 31);
                    default: begin
                        case ($urandom_range(0, 3))
                            0: v = 32'd0;
                            1: v = 32'h7FFF_FFFF;
                            2: v = 32'h8000_0000;
                            default: v = 32'hFFFF_FFFF;
                        endcase
                    end
                endcase
                add_number(v);
            end
        end

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // sample on the falling edge, away from the driver and monitor
        do begin
            @(negedge i_clk);
        end while (jobs.size() != 0 || in_valid || expected_chars.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("summary: %0d numbers converted under %0d radix writes, %0d characters checked",
                 numbers_sent, radix_writes, chars_checked);
        $display("summary: bases 2 to 36 plus out-of-range settings, %0d mismatches",
                 fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
